// ===== rtl/core/i2csmf_pkg.sv =====
// Package for the I2C slave message framer: payload structs, codes, constants.
// No dependencies.
`default_nettype none
package i2csmf_pkg;
  localparam int unsigned BufDepth = 32;
  localparam logic [7:0] ThresholdReset = 8'd4;

  localparam logic [1:0] KIND_MSG = 2'd0;
  localparam logic [1:0] KIND_DBG = 2'd1;
  localparam logic [1:0] KIND_REQ = 2'd2;
  localparam logic [1:0] KIND_STS = 2'd3;

  localparam logic [1:0] ERR_TOOLONG = 2'd0;
  localparam logic [1:0] ERR_OVERRUN = 2'd1;
  localparam logic [1:0] ERR_NOADDR  = 2'd2;
  localparam logic [1:0] ERR_NODATA  = 2'd3;

  typedef enum logic [1:0] {
    BUS_IDLE    = 2'd0,
    BUS_STARTED = 2'd1,
    BUS_SEND    = 2'd2,
    BUS_RECV    = 2'd3
  } bus_state_t;

  typedef struct packed {
    logic       operation;
    logic       overrun;
    logic       buffer_full;
    logic       start_seen;
    logic       stop_seen;
    logic       is_data;
    logic       is_read;
    logic [7:0] data_byte;
    logic       reply_first;
    logic       reply_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       record_end;
    logic       load_tx;
    logic       release_clock;
    logic       last;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/core/i2c_slave_message_framer.sv =====
// I2C slave message framer: bus event state machine, receive and reply stores.
// An input item is registered in SQ_IDLE, updates state in SQ_EXEC, and the
// memories are read in SQ_FETCH; SQ_DRAIN and SQ_TAIL then give one result per
// cycle while out_ready stays high. A new item is accepted only in SQ_IDLE,
// after the last result of the item before; the receive memory is read once per result.
// Reset (rst_n low, synchronous): state idle, counts zero, threshold 4.
`default_nettype none
module i2c_slave_message_framer #(
  parameter int unsigned BUF_DEPTH = i2csmf_pkg::BufDepth
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire i2csmf_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output i2csmf_pkg::out_item_t      out_data,
  input  wire logic                  cfg_we,
  input  wire logic [7:0]            cfg_wdata
);
  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(BUF_DEPTH);

  typedef enum logic [4:0] {
    SQ_IDLE  = 5'b00001,
    SQ_EXEC  = 5'b00010,
    SQ_FETCH = 5'b00100,
    SQ_DRAIN = 5'b01000,
    SQ_TAIL  = 5'b10000
  } seq_t;

  seq_t seq_r, seq_nxt;
  i2csmf_pkg::in_item_t it_r, it_nxt;
  i2csmf_pkg::bus_state_t bus_r, bus_nxt;
  logic [7:0] thr_r, thr_nxt, evt_r, evt_nxt, err_r, err_nxt, dbe_r, dbe_nxt;
  logic [1:0] lerr_r, lerr_nxt;
  logic [CW-1:0] rxc_r, rxc_nxt, txc_r, txc_nxt, txi_r, txi_nxt;
  logic [CW-1:0] drn_r, drn_nxt, len_r, len_nxt;
  logic [AW-1:0] txa_r, txa_nxt;
  // pending tail results: message end, debug record (3 left .. 0), request
  logic msg_r, msg_nxt, ask_r, ask_nxt;
  logic [1:0] dbg_r, dbg_nxt;
  logic sld_r, sld_nxt, srel_r, srel_nxt;
  logic out_valid_r, out_valid_nxt;
  i2csmf_pkg::out_item_t out_data_r, out_data_nxt;
  logic [7:0] rx_q, tx_q;
  logic out_free;

  // memory ports
  logic rx_we, tx_we;
  logic [AW-1:0] rx_wa, rx_ra, tx_wa;

  i2csmf_ram #(.DEPTH(BUF_DEPTH)) u_rx (
    .clk(clk), .we(rx_we), .waddr(rx_wa), .wdata(it_r.data_byte),
    .raddr(rx_ra), .rdata(rx_q));
  i2csmf_ram #(.DEPTH(BUF_DEPTH)) u_tx (
    .clk(clk), .we(tx_we), .waddr(tx_wa), .wdata(it_r.data_byte),
    .raddr(txa_r), .rdata(tx_q));

  assign in_ready = (seq_r == SQ_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // execute-step combinational results
  i2csmf_pkg::bus_state_t bus_x;
  logic [7:0] evt_x, err_x;
  logic [1:0] lerr_x;
  logic [CW-1:0] rxc_x;
  logic got, ready_x, ask_x, wrote_x, store_x;
  logic [CW-1:0] txc_base;

  always_comb begin
    bus_x = bus_r; evt_x = evt_r; err_x = err_r; lerr_x = lerr_r; rxc_x = rxc_r;
    got = it_r.buffer_full; ready_x = 1'b0; ask_x = 1'b0; wrote_x = 1'b0;
    store_x = 1'b0;
    txc_base = it_r.reply_first ? '0 : txc_r;
    if (it_r.overrun) begin
      bus_x = i2csmf_pkg::BUS_IDLE; err_x = err_r + 8'd1;
      lerr_x = i2csmf_pkg::ERR_OVERRUN;
    end else begin
      case (bus_r)
        i2csmf_pkg::BUS_IDLE: begin
          if (it_r.start_seen) begin
            evt_x = 8'd1; rxc_x = '0;
            if (!got) bus_x = i2csmf_pkg::BUS_STARTED;
            else if (it_r.is_data) begin
              err_x = err_r + 8'd1; lerr_x = i2csmf_pkg::ERR_NOADDR;
            end else if (it_r.is_read) begin
              bus_x = i2csmf_pkg::BUS_SEND; got = 1'b0; ask_x = 1'b1;
            end else bus_x = i2csmf_pkg::BUS_RECV;
          end
        end
        i2csmf_pkg::BUS_STARTED: begin
          if (it_r.stop_seen) begin
            evt_x = evt_r + 8'd1;
            if (got) begin
              if (!it_r.is_data) ready_x = 1'b1;
              else begin err_x = err_r + 8'd1; lerr_x = i2csmf_pkg::ERR_NODATA; end
            end
            bus_x = i2csmf_pkg::BUS_IDLE;
          end else if (got) begin
            evt_x = evt_r + 8'd1;
            if (!it_r.is_data) begin
              if (!it_r.is_read) bus_x = i2csmf_pkg::BUS_RECV;
              else begin bus_x = i2csmf_pkg::BUS_SEND; ask_x = 1'b1; got = 1'b0; end
            end else begin
              err_x = err_r + 8'd1; lerr_x = i2csmf_pkg::ERR_NODATA;
              bus_x = i2csmf_pkg::BUS_IDLE;
            end
          end
        end
        i2csmf_pkg::BUS_SEND: begin
          if (txi_r < txc_r && txi_r < DepthC) wrote_x = 1'b1;
          else bus_x = i2csmf_pkg::BUS_IDLE;
        end
        default: begin
          if (it_r.stop_seen) begin
            evt_x = evt_r + 8'd1;
            if (got) begin
              if (it_r.is_data) begin store_x = 1'b1; ready_x = 1'b1; end
              else begin err_x = err_r + 8'd1; lerr_x = i2csmf_pkg::ERR_NODATA; end
            end else ready_x = 1'b1;
            bus_x = i2csmf_pkg::BUS_IDLE;
          end else if (got) begin
            evt_x = evt_r + 8'd1;
            if (it_r.is_data) store_x = 1'b1;
            else if (it_r.is_read) begin
              bus_x = i2csmf_pkg::BUS_SEND; ready_x = 1'b1; ask_x = 1'b1; got = 1'b0;
            end else begin
              err_x = err_r + 8'd1; lerr_x = i2csmf_pkg::ERR_NODATA;
              bus_x = i2csmf_pkg::BUS_IDLE;
            end
          end
        end
      endcase
    end
    if (store_x && rxc_r < DepthC) rxc_x = rxc_r + CW'(1);
    // long message check
    if ((CW+1)'(rxc_x) + (CW+1)'(2) > (CW+1)'(BUF_DEPTH) && !ready_x) begin
      bus_x = i2csmf_pkg::BUS_IDLE; err_x = err_x + 8'd1;
      lerr_x = i2csmf_pkg::ERR_TOOLONG;
    end
  end

  // memory addressing: writes only in EXEC, reads start in FETCH
  always_comb begin
    rx_we = (seq_r == SQ_EXEC) && !it_r.operation && store_x && rxc_r < DepthC;
    rx_wa = rxc_r[AW-1:0];
    tx_we = (seq_r == SQ_EXEC) && it_r.operation && txc_base < DepthC;
    tx_wa = txc_base[AW-1:0];
    if (seq_r == SQ_DRAIN && out_free) rx_ra = drn_r[AW-1:0] + AW'(1);
    else rx_ra = drn_r[AW-1:0];
  end

  // sequencer and next state
  always_comb begin
    seq_nxt = seq_r; it_nxt = it_r; bus_nxt = bus_r;
    thr_nxt = cfg_we ? cfg_wdata : thr_r;
    evt_nxt = evt_r; err_nxt = err_r; dbe_nxt = dbe_r; lerr_nxt = lerr_r;
    rxc_nxt = rxc_r; txc_nxt = txc_r; txi_nxt = txi_r; drn_nxt = drn_r;
    len_nxt = len_r; txa_nxt = txa_r; msg_nxt = msg_r; ask_nxt = ask_r;
    dbg_nxt = dbg_r; sld_nxt = sld_r; srel_nxt = srel_r;
    out_valid_nxt = out_valid_r && !out_ready; out_data_nxt = out_data_r;
    case (seq_r)
      SQ_IDLE: begin
        if (in_valid) begin
          it_nxt = in_data; seq_nxt = SQ_EXEC;
        end
      end
      SQ_EXEC: begin
        seq_nxt = SQ_FETCH; drn_nxt = '0;
        if (it_r.operation) begin
          txc_nxt = txc_base < DepthC ? txc_base + CW'(1) : txc_base;
          if (it_r.reply_last) txi_nxt = CW'(1);
          txa_nxt = '0;
          msg_nxt = 1'b0; ask_nxt = 1'b0; dbg_nxt = '0;
          sld_nxt = it_r.reply_last; srel_nxt = it_r.reply_last;
        end else begin
          bus_nxt = bus_x; evt_nxt = evt_x; lerr_nxt = lerr_x; ask_nxt = ask_x;
          msg_nxt = ready_x; len_nxt = rxc_x; rxc_nxt = ready_x ? '0 : rxc_x;
          txa_nxt = txi_r[AW-1:0];
          if (wrote_x) txi_nxt = txi_r + CW'(1);
          sld_nxt = wrote_x; srel_nxt = got || wrote_x;
          dbe_nxt = err_x; err_nxt = err_x; dbg_nxt = '0;
          if (!ready_x && err_x >= thr_r) begin
            dbg_nxt = 2'd3; err_nxt = '0;
          end
        end
      end
      // memories read the first entries this cycle
      SQ_FETCH: seq_nxt = (msg_r && len_r != '0) ? SQ_DRAIN : SQ_TAIL;
      SQ_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '{i2csmf_pkg::KIND_MSG, rx_q, 1'b0, 1'b0, 1'b0, 1'b0};
          drn_nxt = drn_r + CW'(1);
          if (drn_r + CW'(1) == len_r) seq_nxt = SQ_TAIL;
        end
      end
      SQ_TAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (msg_r) begin
            msg_nxt = 1'b0;
            out_data_nxt = '{i2csmf_pkg::KIND_MSG, evt_r, 1'b1, 1'b0, 1'b0, 1'b0};
          end else if (dbg_r == 2'd3) begin
            dbg_nxt = 2'd2;
            out_data_nxt = '{i2csmf_pkg::KIND_DBG, dbe_r, 1'b0, 1'b0, 1'b0, 1'b0};
          end else if (dbg_r == 2'd2) begin
            dbg_nxt = 2'd1;
            out_data_nxt = '{i2csmf_pkg::KIND_DBG, {6'd0, lerr_r}, 1'b0, 1'b0, 1'b0,
                             1'b0};
          end else if (dbg_r == 2'd1) begin
            dbg_nxt = 2'd0;
            out_data_nxt = '{i2csmf_pkg::KIND_DBG, evt_r, 1'b1, 1'b0, 1'b0, 1'b0};
          end else if (ask_r) begin
            ask_nxt = 1'b0;
            out_data_nxt = '{i2csmf_pkg::KIND_REQ, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0};
          end else begin
            out_data_nxt = '{i2csmf_pkg::KIND_STS, sld_r ? tx_q : 8'd0, 1'b0,
                             sld_r, srel_r, 1'b1};
            seq_nxt = SQ_IDLE;
          end
        end
      end
      default: seq_nxt = SQ_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SQ_IDLE; it_r <= '0; bus_r <= i2csmf_pkg::BUS_IDLE;
      thr_r <= i2csmf_pkg::ThresholdReset; evt_r <= '0; err_r <= '0; dbe_r <= '0;
      lerr_r <= '0; rxc_r <= '0; txc_r <= '0; txi_r <= '0; drn_r <= '0;
      len_r <= '0; txa_r <= '0; msg_r <= 1'b0; ask_r <= 1'b0; dbg_r <= '0;
      sld_r <= 1'b0; srel_r <= 1'b0; out_valid_r <= 1'b0; out_data_r <= '0;
    end else begin
      seq_r <= seq_nxt; it_r <= it_nxt; bus_r <= bus_nxt;
      thr_r <= thr_nxt; evt_r <= evt_nxt; err_r <= err_nxt; dbe_r <= dbe_nxt;
      lerr_r <= lerr_nxt; rxc_r <= rxc_nxt; txc_r <= txc_nxt; txi_r <= txi_nxt;
      drn_r <= drn_nxt; len_r <= len_nxt; txa_r <= txa_nxt; msg_r <= msg_nxt;
      ask_r <= ask_nxt; dbg_r <= dbg_nxt; sld_r <= sld_nxt; srel_r <= srel_nxt;
      out_valid_r <= out_valid_nxt; out_data_r <= out_data_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/i2csmf_ram.sv =====
// Single-port-write, single-read byte memory with registered read data.
// Depends on nothing.
`default_nettype none
module i2csmf_ram #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
